[rtl/core/wea_pkg.sv]
// Shared types and constants for the waveform extrema analyser.
`timescale 1ns / 1ps

package wea_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int IDX_W       = 16;
    localparam int POS_W       = 17;
    localparam int CNT_W       = 17;
    localparam int THR_W       = 31;
    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int SLOT_CNT_W  = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 128;
    localparam int M_PAD_W     = M_TDATA_W - (7 * POS_W) - 2;

    localparam logic [POS_W-1:0] POS_NONE  = '1;
    localparam logic [CNT_W-1:0] TALLY_CAP = 17'd65536;

    // Result kind, carried on m_tuser
    typedef enum logic [1:0] {
        KIND_ZERO    = 2'd0,
        KIND_MIN     = 2'd1,
        KIND_MAX     = 2'd2,
        KIND_SUMMARY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ARRIVAL = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_SHORT   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           idx;
        logic                       first;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   arrival_pos;
        logic [POS_W-1:0]   min_pos;
        logic [POS_W-1:0]   max_pos;
        logic [CNT_W-1:0]   min_count;
        logic [CNT_W-1:0]   max_count;
        logic [CNT_W-1:0]   zero_count;
        status_t            status;
        logic               final_item;
    } result_t;

    // Results caused by one input item, in output order
    typedef struct packed {
        result_t [NUM_SLOTS-1:0] slot;
        logic [SLOT_CNT_W-1:0]   count;
    } batch_t;

endpackage

[rtl/core/wea_core.sv]
// Per-sample decision logic and window state of the extrema analyser.
`timescale 1ns / 1ps

module wea_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  wea_pkg::in_item_t             item,
    input  logic [wea_pkg::THR_W-1:0]     thr,
    output wea_pkg::batch_t               batch
);

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ONE  = 2'd1,
        FILL_MORE = 2'd2
    } fill_t;

    fill_t                                 fill_reg, fill_next;
    logic signed [wea_pkg::SAMPLE_W-1:0]   held_sample_reg, held_sample_next;
    logic signed [wea_pkg::SAMPLE_W-1:0]   older_sample_reg, older_sample_next;
    logic [wea_pkg::IDX_W-1:0]             held_index_reg, held_index_next;
    logic                                  arr_seen_reg, arr_seen_next;
    logic [wea_pkg::POS_W-1:0]             arr_pos_reg, arr_pos_next;
    logic signed [wea_pkg::SAMPLE_W-1:0]   low_val_reg, low_val_next;
    logic [wea_pkg::POS_W-1:0]             low_pos_reg, low_pos_next;
    logic signed [wea_pkg::SAMPLE_W-1:0]   high_val_reg, high_val_next;
    logic [wea_pkg::POS_W-1:0]             high_pos_reg, high_pos_next;
    logic [wea_pkg::CNT_W-1:0]             min_tally_reg, min_tally_next;
    logic [wea_pkg::CNT_W-1:0]             max_tally_reg, max_tally_next;
    logic [wea_pkg::CNT_W-1:0]             zero_tally_reg, zero_tally_next;
    logic                                  clear_win;

    localparam logic signed [wea_pkg::SAMPLE_W-1:0] VAL_MOST_POS =
        {1'b0, {(wea_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [wea_pkg::SAMPLE_W-1:0] VAL_MOST_NEG =
        {1'b1, {(wea_pkg::SAMPLE_W-1){1'b0}}};

    function automatic logic [wea_pkg::SAMPLE_W-1:0] magnitude(
        input logic signed [wea_pkg::SAMPLE_W-1:0] v);
        magnitude = v[wea_pkg::SAMPLE_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic opposite(input logic signed [wea_pkg::SAMPLE_W-1:0] a,
                                      input logic signed [wea_pkg::SAMPLE_W-1:0] b);
        logic a_pos, b_pos;
        a_pos = !a[wea_pkg::SAMPLE_W-1] && (a != '0);
        b_pos = !b[wea_pkg::SAMPLE_W-1] && (b != '0);
        opposite = (a[wea_pkg::SAMPLE_W-1] && b_pos) || (a_pos && b[wea_pkg::SAMPLE_W-1]);
    endfunction

    function automatic logic [wea_pkg::CNT_W-1:0] bump(input logic [wea_pkg::CNT_W-1:0] t);
        bump = (t < wea_pkg::TALLY_CAP) ? t + 1'b1 : t;
    endfunction

    function automatic wea_pkg::result_t event_item(input wea_pkg::kind_t k,
                                                    input logic [wea_pkg::POS_W-1:0] pos);
        wea_pkg::result_t r;
        r.kind        = k;
        r.position    = pos;
        r.arrival_pos = wea_pkg::POS_NONE;
        r.min_pos     = wea_pkg::POS_NONE;
        r.max_pos     = wea_pkg::POS_NONE;
        r.min_count   = '0;
        r.max_count   = '0;
        r.zero_count  = '0;
        r.status      = wea_pkg::STAT_ARRIVAL;
        r.final_item  = 1'b0;
        event_item = r;
    endfunction

    // Decide on the held sample, then on the right edge, and collect results
    always_comb begin
        fill_t                                cur_fill;
        logic signed [wea_pkg::SAMPLE_W-1:0]  x, y, old;
        logic [wea_pkg::POS_W-1:0]            cur_pos, new_pos;
        logic [wea_pkg::SAMPLE_W-1:0]         mag_y, mag_x, thr_w;
        logic                                 go;
        wea_pkg::result_t [wea_pkg::NUM_SLOTS-1:0] cand;
        logic [wea_pkg::NUM_SLOTS-1:0]        cand_v;
        logic [wea_pkg::SLOT_CNT_W-1:0]       n;

        cur_fill          = item.first ? FILL_NONE : fill_reg;
        x                 = item.sample;
        y                 = item.first ? '0 : held_sample_reg;
        old               = item.first ? '0 : older_sample_reg;
        cur_pos           = item.first ? '0 : {1'b0, held_index_reg};
        new_pos           = {1'b0, item.idx};
        mag_y             = magnitude(y);
        mag_x             = magnitude(x);
        thr_w             = {1'b0, thr};
        go                = 1'b0;
        cand              = '0;
        cand_v            = '0;
        n                 = '0;
        clear_win         = 1'b0;

        // Start from the window as it stands after an optional restart
        fill_next         = cur_fill;
        held_sample_next  = y;
        older_sample_next = old;
        held_index_next   = cur_pos[wea_pkg::IDX_W-1:0];
        arr_seen_next     = item.first ? 1'b0 : arr_seen_reg;
        arr_pos_next      = item.first ? wea_pkg::POS_NONE : arr_pos_reg;
        low_val_next      = item.first ? VAL_MOST_POS : low_val_reg;
        low_pos_next      = item.first ? wea_pkg::POS_NONE : low_pos_reg;
        high_val_next     = item.first ? VAL_MOST_NEG : high_val_reg;
        high_pos_next     = item.first ? wea_pkg::POS_NONE : high_pos_reg;
        min_tally_next    = item.first ? '0 : min_tally_reg;
        max_tally_next    = item.first ? '0 : max_tally_reg;
        zero_tally_next   = item.first ? '0 : zero_tally_reg;

        if (cur_fill == FILL_NONE) begin
            held_sample_next = x;
            held_index_next  = item.idx;
            fill_next        = FILL_ONE;
            if (item.last) begin
                clear_win = 1'b1;
            end
        end else begin
            // Decide on the held sample
            if (cur_fill == FILL_ONE) begin
                if (mag_y > thr_w) begin
                    arr_seen_next = 1'b1;
                    arr_pos_next  = cur_pos;
                    go            = 1'b1;
                    cand_v[0]     = opposite(y, x);
                    cand_v[1]     = (x != y);
                    cand[1]       = event_item((x > y) ? wea_pkg::KIND_MIN : wea_pkg::KIND_MAX,
                                               cur_pos);
                end
            end else begin
                if (!arr_seen_next) begin
                    if (mag_y >= thr_w) begin
                        arr_seen_next = 1'b1;
                        arr_pos_next  = cur_pos;
                        go            = 1'b1;
                        cand_v[0]     = 1'b1;
                    end
                end else begin
                    go        = 1'b1;
                    cand_v[0] = opposite(y, x);
                end
                if (go) begin
                    if ((old > y) && (y < x)) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = event_item(wea_pkg::KIND_MIN, cur_pos);
                    end else if ((old < y) && (y > x)) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = event_item(wea_pkg::KIND_MAX, cur_pos);
                    end
                end
            end
            cand[0] = event_item(wea_pkg::KIND_ZERO, cur_pos);

            if (go) begin
                if (low_pos_next[wea_pkg::POS_W-1] || (y < low_val_next)) begin
                    low_val_next = y;
                    low_pos_next = cur_pos;
                end
                if (high_pos_next[wea_pkg::POS_W-1] || (y > high_val_next)) begin
                    high_val_next = y;
                    high_pos_next = cur_pos;
                end
            end

            // Advance the sample line
            older_sample_next = y;
            held_sample_next  = x;
            held_index_next   = item.idx;
            fill_next         = FILL_MORE;

            // Right edge
            if (item.last) begin
                clear_win = 1'b1;
                if (!arr_seen_next && (mag_x > thr_w)) begin
                    arr_seen_next = 1'b1;
                    arr_pos_next  = new_pos;
                end
                if (arr_seen_next) begin
                    cand_v[2] = (x != y);
                    cand[2]   = event_item((x < y) ? wea_pkg::KIND_MIN : wea_pkg::KIND_MAX,
                                           new_pos);
                    if (low_pos_next[wea_pkg::POS_W-1] || (x < low_val_next)) begin
                        low_val_next = x;
                        low_pos_next = new_pos;
                    end
                    if (high_pos_next[wea_pkg::POS_W-1] || (x > high_val_next)) begin
                        high_val_next = x;
                        high_pos_next = new_pos;
                    end
                end
            end
        end

        // Count the reported events
        for (int i = 0; i < wea_pkg::NUM_SLOTS - 1; i++) begin
            if (cand_v[i]) begin
                case (cand[i].kind)
                    wea_pkg::KIND_ZERO: zero_tally_next = bump(zero_tally_next);
                    wea_pkg::KIND_MIN:  min_tally_next  = bump(min_tally_next);
                    wea_pkg::KIND_MAX:  max_tally_next  = bump(max_tally_next);
                    default:            zero_tally_next = zero_tally_next;
                endcase
            end
        end

        // Window summary closes the list
        cand_v[3]            = item.last;
        cand[3]              = event_item(wea_pkg::KIND_SUMMARY, wea_pkg::POS_NONE);
        cand[3].arrival_pos  = arr_pos_next;
        cand[3].min_pos      = low_pos_next;
        cand[3].max_pos      = high_pos_next;
        cand[3].min_count    = min_tally_next;
        cand[3].max_count    = max_tally_next;
        cand[3].zero_count   = zero_tally_next;
        if (cur_fill == FILL_NONE) begin
            cand[3].status = wea_pkg::STAT_SHORT;
        end else if (arr_seen_next) begin
            cand[3].status = wea_pkg::STAT_ARRIVAL;
        end else begin
            cand[3].status = wea_pkg::STAT_NONE;
        end

        // Pack valid results to the front and mark the final one
        batch = '0;
        for (int i = 0; i < wea_pkg::NUM_SLOTS; i++) begin
            if (cand_v[i]) begin
                batch.slot[n[wea_pkg::SLOT_IDX_W-1:0]] = cand[i];
                n = n + 1'b1;
            end
        end
        if (n != '0) begin
            batch.slot[n[wea_pkg::SLOT_IDX_W-1:0] - 1'b1].final_item = 1'b1;
        end
        batch.count = n;
    end

    // Hold window state; a closed window returns to its cleared values
    always_ff @(posedge aclk) begin
        if (!aresetn || (take && clear_win)) begin
            fill_reg         <= FILL_NONE;
            held_sample_reg  <= '0;
            older_sample_reg <= '0;
            held_index_reg   <= '0;
            arr_seen_reg     <= 1'b0;
            arr_pos_reg      <= wea_pkg::POS_NONE;
            low_val_reg      <= VAL_MOST_POS;
            low_pos_reg      <= wea_pkg::POS_NONE;
            high_val_reg     <= VAL_MOST_NEG;
            high_pos_reg     <= wea_pkg::POS_NONE;
            min_tally_reg    <= '0;
            max_tally_reg    <= '0;
            zero_tally_reg   <= '0;
        end else if (take) begin
            fill_reg         <= fill_next;
            held_sample_reg  <= held_sample_next;
            older_sample_reg <= older_sample_next;
            held_index_reg   <= held_index_next;
            arr_seen_reg     <= arr_seen_next;
            arr_pos_reg      <= arr_pos_next;
            low_val_reg      <= low_val_next;
            low_pos_reg      <= low_pos_next;
            high_val_reg     <= high_val_next;
            high_pos_reg     <= high_pos_next;
            min_tally_reg    <= min_tally_next;
            max_tally_reg    <= max_tally_next;
            zero_tally_reg   <= zero_tally_next;
        end
    end

    // Arrival flag and arrival position agree
    a_arrival_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        arr_seen_reg == !arr_pos_reg[wea_pkg::POS_W-1])
        else $error("arrival flag and position disagree");

    // Tallies stay within the saturation cap
    a_tally_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_tally_reg <= wea_pkg::TALLY_CAP) && (max_tally_reg <= wea_pkg::TALLY_CAP) &&
        (zero_tally_reg <= wea_pkg::TALLY_CAP))
        else $error("tally above cap");

    // An empty window carries no arrival, no extremum and no zero count
    a_empty_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == FILL_NONE) |-> (!arr_seen_reg && low_pos_reg[wea_pkg::POS_W-1] &&
        high_pos_reg[wea_pkg::POS_W-1] && (zero_tally_reg == '0)))
        else $error("empty window not cleared");

endmodule

[rtl/core/wea_drain.sv]
// Result buffer and output register: drains one result per transfer.
`timescale 1ns / 1ps

module wea_drain (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  wea_pkg::batch_t                   batch,
    output logic                              batch_ready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wea_pkg::M_TDATA_W-1:0]     m_tdata,   // position, first_arrival_pos,
                                                         // min_pos, max_pos, min_count,
                                                         // max_count, zero_count,
                                                         // window_status, zero pad
    output logic [1:0]                        m_tuser,   // kind
    output logic                              m_tlast    // final_item
);

    wea_pkg::result_t [wea_pkg::NUM_SLOTS-1:0] slot_reg;
    logic [wea_pkg::SLOT_CNT_W-1:0]            rem_reg;
    logic [wea_pkg::SLOT_IDX_W-1:0]            ptr_reg;
    wea_pkg::result_t                          out_reg;
    logic                                      out_valid_reg;
    logic                                      out_load;

    assign out_load    = (rem_reg != '0) && (!out_valid_reg || m_tready);
    assign batch_ready = (rem_reg == '0) || ((rem_reg == 3'd1) && out_load);

    // Advance the read pointer and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                rem_reg       <= rem_reg - 1'b1;
                ptr_reg       <= ptr_reg + 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (load) begin
                rem_reg <= batch.count;
                ptr_reg <= '0;
            end
        end
    end

    // Capture the batch and the next result
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= batch.slot;
        end
        if (out_load) begin
            out_reg <= slot_reg[ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{wea_pkg::M_PAD_W{1'b0}}, out_reg.status, out_reg.zero_count,
                       out_reg.max_count, out_reg.min_count, out_reg.max_pos,
                       out_reg.min_pos, out_reg.arrival_pos, out_reg.position};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.final_item;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 3'd4)
        else $error("buffer count out of range");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, ptr_reg} + rem_reg) <= 3'd4)
        else $error("read pointer runs past the batch");

    // The final mark sits exactly on the last buffered result
    a_final_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (slot_reg[ptr_reg].final_item == (rem_reg == 3'd1)))
        else $error("final mark misplaced");

endmodule

[rtl/core/waveform_extrema_analyser.sv]
// Top level of the waveform extrema analyser: input register, decision core and result drain.
// Path: a sample passes the input register, the result buffer and the output register.
// Results: a sample causes 0 to 4 results; the single output register drains one
//   result per cycle while m_tready is high; the next sample is taken as the last moves out.
// Reset: aresetn is synchronous, active low; it clears the threshold to 0, closes any
//   open window and empties the input register, the result buffer and the output.
`timescale 1ns / 1ps

module waveform_extrema_analyser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [wea_pkg::THR_W-1:0]         cfg_wdata,   // arrival_threshold
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wea_pkg::S_TDATA_W-1:0]     s_tdata,     // sample, sample_index
    input  logic [0:0]                        s_tuser,     // first_sample
    input  logic                              s_tlast,     // last_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wea_pkg::M_TDATA_W-1:0]     m_tdata,     // position, first_arrival_pos,
                                                           // min_pos, max_pos, min_count,
                                                           // max_count, zero_count,
                                                           // window_status, zero pad
    output logic [1:0]                        m_tuser,     // kind
    output logic                              m_tlast      // final_item
);

    logic [wea_pkg::THR_W-1:0]  thr_reg;
    logic                       in_valid_reg;
    wea_pkg::in_item_t          in_item_reg;
    logic                       batch_ready;
    logic                       take;
    wea_pkg::batch_t            batch;

    assign take     = in_valid_reg && batch_ready;
    assign s_tready = !in_valid_reg || batch_ready;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.sample <= s_tdata[wea_pkg::SAMPLE_W-1:0];
            in_item_reg.idx    <= s_tdata[wea_pkg::SAMPLE_W +: wea_pkg::IDX_W];
            in_item_reg.first  <= s_tuser[0];
            in_item_reg.last   <= s_tlast;
        end
    end

    wea_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (in_item_reg),
        .thr     (thr_reg),
        .batch   (batch)
    );

    wea_drain u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (take),
        .batch       (batch),
        .batch_ready (batch_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
